### hdl/sync_frame_receiver_crc16_assert.svh
// Assertion macros shared by the sync frame receiver RTL.
`ifndef SYNC_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sfr_pkg.sv
// Types, constants and the CRC function of the sync frame receiver.
package sfr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_VALUE  = 2'd0;
  localparam logic [1:0] REG_FRAME_BYTES = 2'd1;
  localparam logic [1:0] REG_CRC_START   = 2'd2;

  // Register reset values
  localparam logic [7:0]  SYNC_RESET      = 8'h5A;
  localparam logic [7:0]  FRAME_RESET     = 8'd82;
  localparam logic [15:0] CRC_START_RESET = 16'h0000;

  // Frame layout
  localparam logic [7:0] HDR_LEN     = 8'd6;
  localparam logic [7:0] MIN_FRAME   = 8'd7;
  localparam logic [7:0] HDR_CRC_END = 8'd4;
  localparam logic [7:0] OFS_LEN_LO  = 8'd2;
  localparam logic [7:0] OFS_LEN_HI  = 8'd3;
  localparam logic [7:0] OFS_CRC_LO  = 8'd4;
  localparam logic [7:0] OFS_CRC_HI  = 8'd5;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_offset;
    logic       frame_end;
    logic       crc_ok;
    logic       length_error;
  } result_t;

  // Frame tracker status seen by the top level
  typedef struct packed {
    logic       in_frame;
    logic [7:0] byte_count;
  } core_status_t;

  // CRC-16 over one byte, MSB first, unrolled eight steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/sfr_core.sv
// Frame tracker: configuration registers, header capture, CRC and result build.
module sfr_core import sfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         rx_take,
  input  logic [7:0]   rx_byte,
  output logic         res_push,
  output result_t      res,
  output core_status_t status
);

  logic [7:0]  sync_value;
  logic [7:0]  frame_bytes;
  logic [15:0] crc_start;

  logic        in_frame, in_frame_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] received_crc, received_crc_next;

  logic [7:0]  fl;
  logic [7:0]  p;
  logic        last;
  logic [15:0] crc_upd;
  logic [15:0] crc_final;
  logic        len_err;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value  <= SYNC_RESET;
      frame_bytes <= FRAME_RESET;
      crc_start   <= CRC_START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYNC_VALUE:  sync_value  <= cfg_data[7:0];
        REG_FRAME_BYTES: frame_bytes <= cfg_data[7:0];
        REG_CRC_START:   crc_start   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath terms for the current byte
  always_comb begin
    fl        = (frame_bytes < MIN_FRAME) ? MIN_FRAME : frame_bytes;
    p         = byte_count - HDR_LEN;
    last      = byte_count >= (fl - 8'd1);
    crc_upd   = crc_byte(in_frame ? crc_accum : crc_start, rx_byte);
    crc_final = ({8'h00, p} < declared_length) ? crc_upd : crc_accum;
    len_err   = declared_length > ({8'h00, fl} - {8'h00, HDR_LEN});
  end

  // Next state and result
  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    crc_accum_next       = crc_accum;
    declared_length_next = declared_length;
    received_crc_next    = received_crc;
    res_push             = 1'b0;
    res                  = '0;
    if (rx_take) begin
      if (!in_frame) begin
        if (rx_byte == sync_value) begin
          in_frame_next        = 1'b1;
          byte_count_next      = 8'd1;
          crc_accum_next       = crc_upd;
          declared_length_next = '0;
          received_crc_next    = '0;
        end
      end else if (byte_count < HDR_LEN) begin
        if (byte_count < HDR_CRC_END) begin
          crc_accum_next = crc_upd;
        end
        unique case (byte_count)
          OFS_LEN_LO: declared_length_next = {declared_length[15:8], rx_byte};
          OFS_LEN_HI: declared_length_next = {rx_byte, declared_length[7:0]};
          OFS_CRC_LO: received_crc_next    = {received_crc[15:8], rx_byte};
          OFS_CRC_HI: received_crc_next    = {rx_byte, received_crc[7:0]};
          default: ;
        endcase
        byte_count_next = byte_count + 8'd1;
      end else begin
        crc_accum_next     = crc_final;
        res_push           = 1'b1;
        res.payload_byte   = rx_byte;
        res.payload_offset = p;
        res.frame_end      = last;
        res.crc_ok         = last && (crc_final == received_crc);
        res.length_error   = last && len_err;
        if (last) begin
          in_frame_next   = 1'b0;
          byte_count_next = 8'd0;
        end else begin
          byte_count_next = byte_count + 8'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= 8'd0;
      crc_accum       <= CRC_START_RESET;
      declared_length <= '0;
      received_crc    <= '0;
    end else begin
      in_frame        <= in_frame_next;
      byte_count      <= byte_count_next;
      crc_accum       <= crc_accum_next;
      declared_length <= declared_length_next;
      received_crc    <= received_crc_next;
    end
  end

  assign status.in_frame   = in_frame;
  assign status.byte_count = byte_count;

endmodule

### hdl/sfr_out_buf.sv
// Output register with a skid entry that absorbs one more result under a stall.
module sfr_out_buf import sfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop = main_valid && out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (!main_valid || pop) main_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_data <= skid_data;
    end else if (push) begin
      if (!main_valid || pop) main_data <= push_data;
      else skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

### hdl/sync_frame_receiver_crc16.sv
// Top level of the sync-framed serial receiver with CRC-16 check.
//
//   channel  handshake              payload
//   rx       rx_valid / rx_ready    rx_byte
//   out      out_valid / out_ready  payload_byte payload_offset frame_end crc_ok length_error
//   cfg      cfg_write              cfg_index cfg_data
//
// One byte per cycle while rx_ready is high: each byte updates the frame state and the CRC
// in the cycle it is accepted; a payload result is registered into the output register or
// its skid entry.
// rst is synchronous; it restores the register defaults and returns to hunting for sync.
// A two-entry output buffer absorbs a stall; rx_ready drops only when both entries hold data.
module sync_frame_receiver_crc16 import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_offset,
  output logic        frame_end,
  output logic        crc_ok,
  output logic        length_error
);

`include "sync_frame_receiver_crc16_assert.svh"

  logic         rx_take;
  logic         res_push;
  result_t      res;
  result_t      out_data;
  core_status_t status;
  logic         buf_full;

  assign rx_ready = !buf_full;
  assign rx_take  = rx_valid && rx_ready;

  // Frame tracking and CRC
  sfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_take   (rx_take),
    .rx_byte   (rx_byte),
    .res_push  (res_push),
    .res       (res),
    .status    (status)
  );

  // Result register and skid
  sfr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign payload_byte   = out_data.payload_byte;
  assign payload_offset = out_data.payload_offset;
  assign frame_end      = out_data.frame_end;
  assign crc_ok         = out_data.crc_ok;
  assign length_error   = out_data.length_error;

  // Checks
  `SFR_ASSERT_IMPL(a_flags_with_end, clk, rst, out_valid && !frame_end,
    !crc_ok && !length_error, "status flags set without frame_end")
  `SFR_ASSERT_IMPL(a_stall_needs_main, clk, rst, !rx_ready, out_valid,
    "input stalled while output register empty")
  `SFR_ASSERT_IMPL(a_count_in_frame, clk, rst, status.in_frame, status.byte_count != 8'd0,
    "in frame with zero byte count")
  `SFR_ASSERT_NEXT(a_end_leaves_frame, clk, rst, res_push && res.frame_end,
    !status.in_frame, "frame end did not return to sync hunt")

endmodule
